// File: src/bbpf_pkg.sv
package bbpf_pkg;

	localparam int COORD_W = 12;
	localparam int DIM_W = 13;
	localparam int CFG_IDX_W = 2;
	localparam int MAX_WIDTH_DEF = 4096;
	localparam int DIM_LIMIT = 4096;
	localparam int RESET_WIDTH = 640;
	localparam int RESET_HEIGHT = 480;
	localparam int QDEPTH = 4;
	localparam int QAW = 2;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

	// one classified pixel: candidate mask bit 0 up-left, 1 above,
	// 2 left, 3 the pixel itself
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [3:0]         mask;
		logic               frame_last;
	} bbpf_entry_t;

endpackage

// File: src/binary_border_pixel_finder_core.sv
// Border pixel finder for binary frames streamed in raster order.
// Input channel: in_valid/in_ready with pixel_word; a zero word is background,
// any other word is object. One word is taken per clock when the output side
// keeps up. Output channel: out_valid/out_ready with point_x, point_y,
// last_of_item (final point caused by one input word) and frame_done.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 frame_width,
// 1 frame_height) and cfg_data; cfg_ready is always high, a write restarts the
// frame at column 0, row 0. Other indexes are ignored.
// Flow: a word is registered with its line store read, then classified into
// the queue, then expanded into the output register. Throughput: one word per
// cycle at the input while the queue has room; the output register sends one
// point per cycle while out_ready is high, so a word with several points holds
// the back end while a four-entry queue absorbs the bursts.
// Reset: frame size 640 x 480, counters and window cleared; the line stores are
// not cleared since rows above the frame top are always clipped out.
// When out_ready stays low the queue fills, the front stage holds its word and
// in_ready falls until the receiver takes points again.
module binary_border_pixel_finder_core import bbpf_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [31:0]          pixel_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [COORD_W-1:0]   point_x,
	output logic [COORD_W-1:0]   point_y,
	output logic                 last_of_item,
	output logic                 frame_done
);

	bbpf_entry_t push_entry, head;
	logic        push, q_full, q_empty, pop;

	// registers are plain flops, so every write lands at once
	assign cfg_ready = 1'b1;

	// front: count position, read line stores, classify the four candidates
	bbpf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_word (pixel_word),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	// queue of classified words that have at least one border point
	bbpf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.empty      (q_empty),
		.head       (head)
	);

	// back: expand each queued word into points, one per cycle while out_ready is high
	bbpf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (q_empty),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.point_x      (point_x),
		.point_y      (point_y),
		.last_of_item (last_of_item),
		.frame_done   (frame_done)
	);

endmodule

// File: src/bbpf_front.sv
module bbpf_front import bbpf_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [31:0]          pixel_word,
	output logic                 push,
	output bbpf_entry_t          push_entry,
	input  logic                 q_full
);

	localparam int LIM = (MAX_WIDTH < DIM_LIMIT) ? MAX_WIDTH : DIM_LIMIT;
	localparam int AW = $clog2(LIM);

	function automatic logic [COORD_W-1:0] clamp_m1(input logic [DIM_W-1:0] v, input int lim);
		logic [DIM_W-1:0] e;
		e = v;
		if (v == '0)
			e = DIM_W'(1);
		else if (v > DIM_W'(lim))
			e = DIM_W'(lim);
		clamp_m1 = COORD_W'(e - DIM_W'(1));
	endfunction

	// border test of window cell (cc,rr) at frame position (px,py)
	function automatic logic border_f(input logic [8:0] win, input int cc, input int rr,
		input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
		input logic [COORD_W-1:0] wm1, input logic [COORD_W-1:0] hm1);
		logic hit;
		logic corner;
		int c;
		int r;
		int dc;
		int dr;
		hit = 1'b0;
		for (dc = -1; dc <= 1; dc++) begin
			for (dr = -1; dr <= 1; dr++) begin
				c = cc + dc;
				r = rr + dr;
				if (c >= 0 && c <= 2 && r >= 0 && r <= 2
				    && !(dc < 0 && px == '0) && !(dc > 0 && px == wm1)
				    && !(dr < 0 && py == '0) && !(dr > 0 && py == hm1))
					hit = hit | win[c*3+r];
			end
		end
		corner = (px == '0 || px == wm1) && (py == '0 || py == hm1);
		border_f = !win[cc*3+rr] & (hit | corner);
	endfunction

	logic [COORD_W-1:0] w_m1_q, h_m1_q, x_q, y_q;
	logic [8:0]         win_q;
	logic               s1_valid_q;
	logic [COORD_W-1:0] x_s1, y_s1;
	logic               bg_s1, lcol_s1, lrow_s1, fwd_s1;
	logic [1:0]         rd_s1, fwd_data_s1;
	logic [1:0]         mem [LIM];

	logic               in_fire, fire, cfg_hit, bg_in;
	logic [AW-1:0]      rd_addr, wr_addr;
	logic [1:0]         word, wr_data;
	logic [8:0]         win_new;
	logic [COORD_W-1:0] xm1, ym1;
	logic [3:0]         en, mask;

	assign cfg_hit = cfg_valid && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT);
	assign fire = s1_valid_q && !q_full;
	assign in_ready = !s1_valid_q || fire;
	assign in_fire = in_valid && in_ready;
	assign bg_in = (pixel_word == '0);
	assign rd_addr = x_q[AW-1:0];
	assign wr_addr = x_s1[AW-1:0];

	// take the word just written when this pixel read the same entry at that edge
	assign word = fwd_s1 ? fwd_data_s1 : rd_s1;
	assign wr_data = {bg_s1, word[1]};
	assign win_new = {bg_s1, word[1], word[0], win_q[8:3]};
	assign xm1 = x_s1 - COORD_W'(1);
	assign ym1 = y_s1 - COORD_W'(1);

	always_comb begin
		en[0] = (y_s1 != '0) && (x_s1 != '0);
		en[1] = (y_s1 != '0) && lcol_s1;
		en[2] = lrow_s1 && (x_s1 != '0);
		en[3] = lrow_s1 && lcol_s1;
		mask[0] = en[0] && border_f(win_new, 1, 1, xm1, ym1, w_m1_q, h_m1_q);
		mask[1] = en[1] && border_f(win_new, 2, 1, x_s1, ym1, w_m1_q, h_m1_q);
		mask[2] = en[2] && border_f(win_new, 1, 2, xm1, y_s1, w_m1_q, h_m1_q);
		mask[3] = en[3] && border_f(win_new, 2, 2, x_s1, y_s1, w_m1_q, h_m1_q);
	end

	assign push = fire && (mask != '0);
	assign push_entry = '{x: x_s1, y: y_s1, mask: mask, frame_last: lcol_s1 && lrow_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_m1_q <= COORD_W'(RESET_WIDTH - 1);
			h_m1_q <= COORD_W'(RESET_HEIGHT - 1);
			x_q <= '0;
			y_q <= '0;
			win_q <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (cfg_hit) begin
				if (cfg_index == CFG_FRAME_WIDTH)
					w_m1_q <= clamp_m1(cfg_data, LIM);
				else
					h_m1_q <= clamp_m1(cfg_data, DIM_LIMIT);
				x_q <= '0;
				y_q <= '0;
				win_q <= '0;
			end else begin
				if (in_fire) begin
					if (x_q == w_m1_q) begin
						x_q <= '0;
						y_q <= (y_q == h_m1_q) ? '0 : y_q + COORD_W'(1);
					end else begin
						x_q <= x_q + COORD_W'(1);
					end
				end
				if (fire)
					win_q <= win_new;
			end
			if (in_fire)
				s1_valid_q <= 1'b1;
			else if (fire)
				s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_s1 <= x_q;
			y_s1 <= y_q;
			bg_s1 <= bg_in;
			lcol_s1 <= (x_q == w_m1_q);
			lrow_s1 <= (y_q == h_m1_q);
			fwd_s1 <= fire && (wr_addr == rd_addr);
			fwd_data_s1 <= wr_data;
		end
	end

	// line stores: bit 1 row above, bit 0 two rows above
	always_ff @(posedge clk) begin
		if (in_fire)
			rd_s1 <= mem[rd_addr];
		if (fire)
			mem[wr_addr] <= wr_data;
	end

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !fire |=> s1_valid_q && $stable(x_s1) && $stable(y_s1))
		else $error("stalled pixel left the front stage");

	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> x_s1 <= w_m1_q && y_s1 <= h_m1_q)
		else $error("pixel position beyond frame size");

endmodule

// File: src/bbpf_queue.sv
module bbpf_queue import bbpf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  bbpf_entry_t push_entry,
	output logic        full,
	input  logic        pop,
	output logic        empty,
	output bbpf_entry_t head
);

	bbpf_entry_t      ent_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QAW:0]     cnt_q;

	assign full = (cnt_q == (QAW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (QAW+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (QAW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_entry;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue read while empty");

endmodule

// File: src/bbpf_back.sv
module bbpf_back import bbpf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  bbpf_entry_t        head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COORD_W-1:0] point_x,
	output logic [COORD_W-1:0] point_y,
	output logic               last_of_item,
	output logic               frame_done
);

	logic               busy_q, valid_q;
	logic [3:0]         rem_q;
	logic [COORD_W-1:0] px_q, py_q;
	logic               last_q, done_q;

	logic [3:0]         cur, pick, rest;
	logic               load, last;
	logic [COORD_W-1:0] nx, ny;

	assign cur = busy_q ? rem_q : head.mask;
	assign load = !empty && (!valid_q || out_ready);

	// advance to the lowest pending candidate
	always_comb begin
		pick = 4'b0000;
		if (cur[0])
			pick = 4'b0001;
		else if (cur[1])
			pick = 4'b0010;
		else if (cur[2])
			pick = 4'b0100;
		else if (cur[3])
			pick = 4'b1000;
		rest = cur & ~pick;
		last = (rest == '0);
		nx = (pick[0] || pick[2]) ? head.x - COORD_W'(1) : head.x;
		ny = (pick[0] || pick[1]) ? head.y - COORD_W'(1) : head.y;
	end

	assign pop = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				busy_q <= !last;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= rest;
			px_q <= nx;
			py_q <= ny;
			last_q <= last;
			done_q <= last && head.frame_last;
		end
	end

	assign out_valid = valid_q;
	assign point_x = px_q;
	assign point_y = py_q;
	assign last_of_item = last_q;
	assign frame_done = done_q;

	a_busy_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !empty && rem_q != '0)
		else $error("pending points without a queued pixel");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && done_q |-> last_q)
		else $error("frame end flagged on a point that is not final");

endmodule
